// ----- hdl/lec_pkg.sv -----
// Shared constants, defaults and controller/datapath interface structs
// for the largest Euclidean cluster core. No dependencies.
package lec_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;

  localparam int TOL_W  = 16;
  localparam int SIZE_W = 7;
  localparam int SLOT_W = 6;
  localparam int SQ_W   = 2 * TOL_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAST    = 1'b1;

  localparam logic [TOL_W-1:0]  JOIN_TOL_RST = 16'd205;
  localparam logic [SIZE_W-1:0] LEAST_RST    = 7'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld;         // accept a point beat
    logic init;       // start of clustering
    logic i_inc;
    logic seed;       // open a new cluster at seed index i
    logic q_rd;       // read queue head
    logic pop;        // take dequeued index as current point
    logic cur_ld;     // latch current point coordinates
    logic j_inc;
    logic b_ld;       // latch candidate coordinates
    logic push;       // mark j visited and enqueue it
    logic end_c;      // close current cluster
    logic o_start;
    logic o_rd;
    logic o_inc;
    logic emit;       // drive a result for point o
    logic emit_none;  // drive the single no-cluster result
    logic clear;      // end of run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_end;
    logic vis_i;
    logic q_empty;
    logic j_end;
    logic vis_j;
    logic joined;
    logic best_o;
    logic last;
    logic best_zero;
  } stat_t;

endpackage

// ----- hdl/largest_euclidean_cluster_core.sv -----
// Largest Euclidean cluster core: loads a point set, flood-fills clusters and emits the
// largest qualifying one, or the single no-cluster result. Loading takes one beat per
// cycle while idle; clustering runs the distance test for each unvisited candidate;
// output scans the indices and emits each member of the best cluster, each result
// registered, and the receiver cannot stall results. Throughput: one set at a time.
// Reset (rst, synchronous) clears control state and restores the registers.
module largest_euclidean_cluster_core #(
  parameter int MAX_POINTS = lec_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = lec_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  input  logic                          final_point,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lec_pkg::TOL_W-1:0]     cfg_data,
  output logic                          result_valid,
  output logic [lec_pkg::SLOT_W-1:0]    point_slot,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic signed [COORD_BITS-1:0]  out_z,
  output logic [lec_pkg::SIZE_W-1:0]    best_size,
  output logic                          found,
  output logic                          overflowed,
  output logic                          run_end
);

  // The controller walks the seeds, the queue and the candidate scan; the
  // datapath holds all memories, counters and the distance pipeline.
  lec_pkg::cmd_t  cmd;
  lec_pkg::stat_t stat;

  // Configuration beats are always taken; the sender must send them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  lec_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .final_point (final_point),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  lec_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .point_slot   (point_slot),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .best_size    (best_size),
    .found        (found),
    .overflowed   (overflowed),
    .run_end      (run_end)
  );

`ifndef SYNTH
  // The final beat of a run leaves the block ready for a new set.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_end |-> !busy)
    else $error("run ended while still busy");

  // Intermediate beats of a run come while the block is still working.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_end |-> busy)
    else $error("intermediate result while idle");

  // A found cluster carries a nonzero size.
  a_found_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> best_size != '0)
    else $error("found cluster with zero size");

  // The no-cluster result is a run of one beat.
  a_none_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> run_end)
    else $error("no-cluster result not marked as run end");
`endif

endmodule

// ----- hdl/lec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lec_ctrl.sv -----
// Controller state machine for the cluster core: sequences loading,
// flood fill, best-cluster selection and output. Depends on lec_pkg.
module lec_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           final_point,
  input  lec_pkg::stat_t stat,
  output lec_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPW  = 4'd4;
  localparam logic [3:0] S_CUR   = 4'd5;
  localparam logic [3:0] S_JCHK  = 4'd6;
  localparam logic [3:0] S_JW    = 4'd7;
  localparam logic [3:0] S_P1    = 4'd8;
  localparam logic [3:0] S_P2    = 4'd9;
  localparam logic [3:0] S_P3    = 4'd10;
  localparam logic [3:0] S_P4    = 4'd11;
  localparam logic [3:0] S_ENDC  = 4'd12;
  localparam logic [3:0] S_OSCAN = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state, state_next;

  assign busy = (state != S_LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (start) begin
          cmd.ld = 1'b1;
          if (final_point) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_SEED;
      end
      S_SEED: begin
        if (stat.i_end) begin
          if (stat.best_zero) begin
            cmd.emit_none = 1'b1;
            cmd.clear     = 1'b1;
            state_next    = S_LOAD;
          end else begin
            cmd.o_start = 1'b1;
            state_next  = S_OSCAN;
          end
        end else if (stat.vis_i) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.seed   = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (stat.q_empty) begin
          state_next = S_ENDC;
        end else begin
          cmd.q_rd   = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop    = 1'b1;
        state_next = S_CUR;
      end
      S_CUR: begin
        cmd.cur_ld = 1'b1;
        state_next = S_JCHK;
      end
      S_JCHK: begin
        if (stat.j_end) begin
          state_next = S_POP;
        end else if (stat.vis_j) begin
          cmd.j_inc = 1'b1;
        end else begin
          state_next = S_JW;
        end
      end
      S_JW: begin
        cmd.b_ld   = 1'b1;
        state_next = S_P1;
      end
      S_P1: state_next = S_P2;
      S_P2: state_next = S_P3;
      S_P3: state_next = S_P4;
      S_P4: begin
        cmd.push   = stat.joined;
        cmd.j_inc  = 1'b1;
        state_next = S_JCHK;
      end
      S_ENDC: begin
        cmd.end_c  = 1'b1;
        cmd.i_inc  = 1'b1;
        state_next = S_SEED;
      end
      S_OSCAN: begin
        if (stat.best_o) begin
          cmd.o_rd   = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.o_inc = 1'b1;
        end
      end
      S_OUT: begin
        cmd.emit  = 1'b1;
        cmd.o_inc = 1'b1;
        if (stat.last) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_OSCAN;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/lec_dp.sv -----
// Datapath of the cluster core: point and queue memories, visit and
// membership bits, distance test pipeline, result registers.
// Depends on lec_pkg and lec_ram.
module lec_dp #(
  parameter int MAX_POINTS = lec_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = lec_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lec_pkg::cmd_t                  cmd,
  output lec_pkg::stat_t                 stat,
  input  logic signed [COORD_BITS-1:0]   pos_x,
  input  logic signed [COORD_BITS-1:0]   pos_y,
  input  logic signed [COORD_BITS-1:0]   pos_z,
  input  logic                           cfg_we,
  input  logic [lec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lec_pkg::TOL_W-1:0]      cfg_data,
  output logic                           result_valid,
  output logic [lec_pkg::SLOT_W-1:0]     point_slot,
  output logic signed [COORD_BITS-1:0]   out_x,
  output logic signed [COORD_BITS-1:0]   out_y,
  output logic signed [COORD_BITS-1:0]   out_z,
  output logic [lec_pkg::SIZE_W-1:0]     best_size,
  output logic                           found,
  output logic                           overflowed,
  output logic                           run_end
);

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = 3 * C;
  localparam int DW    = (C + 1 > lec_pkg::TOL_W) ? C + 1 : lec_pkg::TOL_W;
  localparam int TW    = lec_pkg::TOL_W;
  localparam int SW    = lec_pkg::SQ_W;

  logic [TW-1:0]                 tol;
  logic [lec_pkg::SIZE_W-1:0]    least;
  logic [SW-1:0]                 tolsq;
  logic [CNT_W-1:0]              count, i, j, o, head, tail, size, bsize, emitted;
  logic                          drop;
  logic [MAX_POINTS-1:0]         visited, cur_mask, best_mask;
  logic [C-1:0]                  cur_x, cur_y, cur_z, b_x, b_y, b_z;
  logic [C:0]                    d1x, d1y, d1z;
  logic [TW-1:0]                 ax, ay, az;
  logic [2:0]                    near2, near3;
  logic [SW-1:0]                 sqx, sqy, sqz;

  logic              p_we;
  logic [IDX_W-1:0]  p_raddr;
  logic [PW-1:0]     p_rdata;
  logic              q_we;
  logic [IDX_W-1:0]  q_waddr, q_wdata, q_rdata;

  assign p_we    = cmd.ld && (count < CNT_W'(MAX_POINTS));
  assign p_raddr = cmd.pop ? q_rdata : (cmd.o_rd ? o[IDX_W-1:0] : j[IDX_W-1:0]);

  lec_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
    .clk   (clk),
    .we    (p_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({pos_z, pos_y, pos_x}),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign q_we    = cmd.seed || cmd.push;
  assign q_waddr = cmd.seed ? '0 : tail[IDX_W-1:0];
  assign q_wdata = cmd.seed ? i[IDX_W-1:0] : j[IDX_W-1:0];

  lec_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (q_rdata)
  );

  // Distance test: differences, magnitudes against the tolerance, squares,
  // then the sum compare feeding the controller.
  logic [C:0]      mx, my, mz;
  logic [DW-1:0]   ex, ey, ez, etol;
  logic [SW+1:0]   sum;

  always_comb begin
    mx   = d1x[C] ? (~d1x + 1'b1) : d1x;
    my   = d1y[C] ? (~d1y + 1'b1) : d1y;
    mz   = d1z[C] ? (~d1z + 1'b1) : d1z;
    ex   = DW'(mx);
    ey   = DW'(my);
    ez   = DW'(mz);
    etol = DW'(tol);
    sum  = (SW+2)'(sqx) + (SW+2)'(sqy) + (SW+2)'(sqz);
  end

  always_ff @(posedge clk) begin
    d1x   <= {cur_x[C-1], cur_x} - {b_x[C-1], b_x};
    d1y   <= {cur_y[C-1], cur_y} - {b_y[C-1], b_y};
    d1z   <= {cur_z[C-1], cur_z} - {b_z[C-1], b_z};
    near2 <= {ez <= etol, ey <= etol, ex <= etol};
    ax    <= ex[TW-1:0];
    ay    <= ey[TW-1:0];
    az    <= ez[TW-1:0];
    sqx   <= ax * ax;
    sqy   <= ay * ay;
    sqz   <= az * az;
    near3 <= near2;
    if (cmd.cur_ld) begin
      {cur_z, cur_y, cur_x} <= p_rdata;
    end
    if (cmd.b_ld) begin
      {b_z, b_y, b_x} <= p_rdata;
    end
    if (cmd.init) begin
      tolsq <= tol * tol;
    end
  end

  always_comb begin
    stat.i_end     = (i == count);
    stat.vis_i     = visited[i[IDX_W-1:0]];
    stat.q_empty   = (head == tail);
    stat.j_end     = (j == count);
    stat.vis_j     = visited[j[IDX_W-1:0]];
    stat.joined    = (&near3) && (sum <= (SW+2)'(tolsq));
    stat.best_o    = best_mask[o[IDX_W-1:0]];
    stat.last      = (CNT_W'(emitted + 1'b1) == bsize);
    stat.best_zero = (bsize == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol          <= lec_pkg::JOIN_TOL_RST;
      least        <= lec_pkg::LEAST_RST;
      count        <= '0;
      drop         <= 1'b0;
      visited      <= '0;
      bsize        <= '0;
      result_valid <= 1'b0;
      i            <= '0;
      j            <= '0;
      o            <= '0;
      head         <= '0;
      tail         <= '0;
      size         <= '0;
      emitted      <= '0;
    end else begin
      result_valid <= cmd.emit || cmd.emit_none;
      if (cfg_we) begin
        case (cfg_index)
          lec_pkg::REG_JOIN_TOL: tol   <= cfg_data;
          lec_pkg::REG_LEAST:    least <= cfg_data[lec_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.ld) begin
        if (p_we) begin
          count <= count + 1'b1;
        end else begin
          drop <= 1'b1;
        end
      end
      if (cmd.init) begin
        i       <= '0;
        bsize   <= '0;
        visited <= '0;
      end
      if (cmd.i_inc) begin
        i <= i + 1'b1;
      end
      if (cmd.seed) begin
        visited[i[IDX_W-1:0]] <= 1'b1;
        head <= '0;
        tail <= CNT_W'(1);
        size <= '0;
      end
      if (cmd.q_rd) begin
        head <= head + 1'b1;
      end
      if (cmd.pop) begin
        size <= size + 1'b1;
      end
      if (cmd.cur_ld) begin
        j <= '0;
      end
      if (cmd.j_inc) begin
        j <= j + 1'b1;
      end
      if (cmd.push) begin
        visited[j[IDX_W-1:0]] <= 1'b1;
        tail <= tail + 1'b1;
      end
      if (cmd.end_c) begin
        if ((8'(size) >= 8'(least)) && (size > bsize)) begin
          bsize <= size;
        end
      end
      if (cmd.o_start) begin
        o       <= '0;
        emitted <= '0;
      end
      if (cmd.o_inc) begin
        o <= o + 1'b1;
      end
      if (cmd.emit) begin
        emitted <= emitted + 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
        drop  <= 1'b0;
      end
    end
  end

  // Membership bits need no reset: they are rebuilt before any use.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_mask <= '0;
    end
    if (cmd.seed) begin
      cur_mask <= '0;
    end
    if (cmd.pop) begin
      cur_mask[q_rdata] <= 1'b1;
    end
    if (cmd.end_c && (8'(size) >= 8'(least)) && (size > bsize)) begin
      best_mask <= cur_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_slot <= lec_pkg::SLOT_W'(o);
      {out_z, out_y, out_x} <= p_rdata;
      best_size  <= lec_pkg::SIZE_W'(bsize);
      found      <= 1'b1;
      overflowed <= drop;
      run_end    <= stat.last;
    end else if (cmd.emit_none) begin
      point_slot <= '0;
      out_x      <= '0;
      out_y      <= '0;
      out_z      <= '0;
      best_size  <= '0;
      found      <= 1'b0;
      overflowed <= drop;
      run_end    <= 1'b1;
    end
  end

endmodule

// ----- bench/tb_largest_euclidean_cluster_core.sv -----
// Testbench for largest_euclidean_cluster_core: drives point sets and register
// writes, predicts the chosen cluster and checks every result beat.
// Depends on lec_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_largest_euclidean_cluster_core;

  localparam int NPTS = 64;
  localparam int CW = 24;
  localparam int IDLE_LIMIT = 200000;

  // One expected result beat.
  typedef struct {
    logic [lec_pkg::SLOT_W-1:0] slot;
    logic [CW-1:0] x, y, z;
    logic [lec_pkg::SIZE_W-1:0] size;
    logic found, ovf, last;
  } member_t;

  // One directed stimulus row. A row with check_empty set also states that
  // the set it closes must yield the single no-cluster result.
  typedef struct {
    logic [CW-1:0] x, y, z;
    logic fin;
    logic check_empty;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic final_point = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lec_pkg::CFG_IDX_W-1:0] cfg_index = lec_pkg::REG_JOIN_TOL;
  logic [lec_pkg::TOL_W-1:0] cfg_data = '0;
  logic result_valid;
  logic [lec_pkg::SLOT_W-1:0] point_slot;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic [lec_pkg::SIZE_W-1:0] best_size;
  logic found, overflowed, run_end;

  largest_euclidean_cluster_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .final_point(final_point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .point_slot(point_slot),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .best_size(best_size),
    .found(found), .overflowed(overflowed), .run_end(run_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the point set being loaded and the register copies.
  logic signed [CW-1:0] set_x[NPTS], set_y[NPTS], set_z[NPTS];
  int unsigned set_count;
  logic set_dropped;
  logic [lec_pkg::TOL_W-1:0] tol_reg;
  logic [lec_pkg::SIZE_W-1:0] least_reg;

  member_t cluster_q[$];
  int errors = 0;
  int idle_cycles = 0;

  // Points join when every axis gap is within tolerance and the squared
  // distance is no greater than the squared tolerance.
  function automatic bit near(int a, int b);
    longint dx, dy, dz, t;
    dx = longint'(set_x[a]) - longint'(set_x[b]);
    dy = longint'(set_y[a]) - longint'(set_y[b]);
    dz = longint'(set_z[a]) - longint'(set_z[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    t = longint'(tol_reg);
    if (dx > t || dy > t || dz > t) return 1'b0;
    return dx * dx + dy * dy + dz * dz <= t * t;
  endfunction

  // Flood-fill the loaded set and queue the winning cluster's members.
  task automatic predict_cluster();
    bit seen[NPTS];
    int label[NPTS];
    int fifo[NPTS];
    int head, tail, size, cur, win_label, win_size;
    member_t m;
    win_label = 0;
    win_size = 0;
    foreach (seen[k]) seen[k] = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      if (seen[i]) continue;
      seen[i] = 1'b1;
      head = 0;
      tail = 1;
      size = 0;
      fifo[0] = i;
      while (head < tail) begin
        cur = fifo[head++];
        label[cur] = i;
        size++;
        for (int j = 0; j < set_count; j++) begin
          if (!seen[j] && near(cur, j)) begin
            seen[j] = 1'b1;
            fifo[tail++] = j;
          end
        end
      end
      if (size >= least_reg && size > win_size) begin
        win_size = size;
        win_label = i;
      end
    end
    if (win_size == 0) begin
      m = '{slot: '0, x: '0, y: '0, z: '0, size: '0, found: 1'b0,
            ovf: set_dropped, last: 1'b1};
      cluster_q.insert(cluster_q.size(), m);
    end else begin
      for (int i = 0; i < set_count; i++) begin
        if (label[i] != win_label) continue;
        m = '{slot: i[lec_pkg::SLOT_W-1:0], x: set_x[i], y: set_y[i], z: set_z[i],
              size: win_size[lec_pkg::SIZE_W-1:0], found: 1'b1, ovf: set_dropped,
              last: 1'b0};
        cluster_q.insert(cluster_q.size(), m);
      end
      cluster_q[cluster_q.size() - 1].last = 1'b1;
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  // Drive one point beat after a random gap and wait until it is taken.
  // Start stays high after the beat until the next gap or the next idle
  // stretch drops it.
  task automatic send_point(logic [CW-1:0] x, y, z, logic fin);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    final_point <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The beat is taken at this edge; update the prediction to match.
    if (set_count < NPTS) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_z[set_count] = z;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (fin) predict_cluster();
  endtask

  // Register writes happen only once the block has drained, plus a margin
  // so the output pass is surely over.
  task automatic write_reg(logic [lec_pkg::CFG_IDX_W-1:0] idx,
                           logic [lec_pkg::TOL_W-1:0] val);
    start <= 1'b0;
    while (cluster_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lec_pkg::REG_JOIN_TOL) tol_reg = val;
    else least_reg = val[lec_pkg::SIZE_W-1:0];
  endtask

  // Random set: a few blobs of nearby points with a sprinkling of strays.
  task automatic random_set(int n);
    logic signed [CW-1:0] cx, cy, cz;
    int sp;
    sp = (tol_reg == 0) ? 1 : int'(tol_reg) / 2 + 1;
    for (int k = 0; k < n; k++) begin
      if (k % 6 == 0 || $urandom_range(0, 9) == 0) begin
        cx = CW'($urandom);
        cy = CW'($urandom);
        cz = CW'($urandom);
      end
      if ($urandom_range(0, 7) == 0)
        send_point(CW'($urandom), CW'($urandom), CW'($urandom), k == n - 1);
      else
        send_point(CW'(cx + $urandom_range(0, sp) - sp / 2),
                   CW'(cy + $urandom_range(0, sp) - sp / 2),
                   CW'(cz + $urandom_range(0, sp) - sp / 2), k == n - 1);
    end
  endtask

  // Result monitor: the block cannot be stalled, so every strobed beat is
  // compared at once against the oldest expected member.
  always @(posedge clk) begin
    member_t e;
    if (!rst && result_valid) begin
      if (cluster_q.size() == 0) begin
        $error("unexpected result beat, slot %0d", point_slot);
        errors++;
      end else begin
        e = cluster_q.pop_front();
        if (point_slot !== e.slot) begin
          $error("point_slot expected %0d actual %0d", e.slot, point_slot); errors++;
        end
        if (out_x !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z); errors++;
        end
        if (best_size !== e.size) begin
          $error("best_size expected %0d actual %0d", e.size, best_size); errors++;
        end
        if (found !== e.found) begin
          $error("found expected %0b actual %0b", e.found, found); errors++;
        end
        if (overflowed !== e.ovf) begin
          $error("overflowed expected %0b actual %0b", e.ovf, overflowed); errors++;
        end
        if (run_end !== e.last) begin
          $error("run_end expected %0b actual %0b", e.last, run_end); errors++;
        end
      end
    end
  end

  // Watchdog: any accepted point, register write or result resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_largest_euclidean_cluster_core: done, errors");
      $finish;
    end
  end

  // Directed rows. The first set runs with reset registers: a lone point at
  // the coordinate extremes is below the default size of five, so it must
  // give the no-cluster result.
  row_t dir_rows[11] = '{
    '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1, 1'b1},
    // Five points on a line at the default tolerance: one cluster of five.
    '{24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0},
    '{24'h0000CD, 24'h000000, 24'h000000, 1'b0, 1'b0},
    '{24'h00019A, 24'h000000, 24'h000000, 1'b0, 1'b0},
    '{24'h000267, 24'h000000, 24'h000000, 1'b0, 1'b0},
    '{24'h000334, 24'h000000, 24'h000000, 1'b1, 1'b0},
    // Just beyond tolerance on the diagonal: gaps pass per axis but not squared.
    '{24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0},
    '{24'h000091, 24'h000091, 24'h000000, 1'b0, 1'b0},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0},
    '{24'hFFFF70, 24'hFFFF70, 24'hFFFFFF, 1'b0, 1'b0},
    '{24'h800000, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0}
  };

  initial begin
    set_count = 0;
    set_dropped = 1'b0;
    tol_reg = lec_pkg::JOIN_TOL_RST;
    least_reg = lec_pkg::LEAST_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z, dir_rows[r].fin);
      if (dir_rows[r].check_empty && !(cluster_q.size() == 1 && !cluster_q[0].found)) begin
        $error("found expected 0 for a lone point at default size");
        errors++;
      end
    end

    // Size zero: every cluster qualifies, so a two-cluster tie goes to the first.
    write_reg(lec_pkg::REG_LEAST, lec_pkg::TOL_W'(0));
    send_point(24'h000010, 24'h000020, 24'h000030, 1'b0);
    send_point(24'h400000, 24'h400000, 24'h400000, 1'b1);
    // Size above capacity: nothing can qualify.
    write_reg(lec_pkg::REG_LEAST, lec_pkg::TOL_W'(64 + $urandom_range(1, 63)));
    random_set(4);
    // Zero tolerance joins only identical points; overfill to force drops,
    // with the dropped point being the final one.
    write_reg(lec_pkg::REG_JOIN_TOL, lec_pkg::TOL_W'(0));
    write_reg(lec_pkg::REG_LEAST, lec_pkg::TOL_W'(1));
    for (int k = 0; k < 66; k++)
      send_point(CW'(k % 3), 24'h000000, 24'hFFFFFF, k == 65);
    // Widest tolerance: most random points fall into one cluster.
    write_reg(lec_pkg::REG_JOIN_TOL, 16'hFFFF);
    random_set(6);

    // Random part: settings change between sets, sets stay small.
    for (int s = 0; s < 16; s++) begin
      if ($urandom_range(0, 2) == 0)
        write_reg(lec_pkg::REG_JOIN_TOL, lec_pkg::TOL_W'(($urandom_range(0, 5) == 0) ?
                  $urandom : $urandom_range(0, 600)));
      if ($urandom_range(0, 2) == 0)
        write_reg(lec_pkg::REG_LEAST, lec_pkg::TOL_W'($urandom_range(0, 8)));
      random_set($urandom_range(1, 10));
    end

    start <= 1'b0;
    while (cluster_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_largest_euclidean_cluster_core: done, clean");
    else
      $display("tb_largest_euclidean_cluster_core: done, errors");
    $finish;
  end
endmodule
